@@ rtl/i8mm_pkg.sv @@
`timescale 1ns / 1ps

package i8mm_pkg;

    localparam int WORD_INDEX_W = 6;
    localparam int DATA_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int LANES        = DATA_W / BYTE_W;

    localparam int MATRIX_DIM_DEF  = 4;
    localparam int A_BASE_WORD_DEF = 0;
    localparam int B_BASE_WORD_DEF = 4;
    localparam int CTRL_WORD_DEF   = 8;
    localparam int STATUS_WORD_DEF = 9;
    localparam int C_BASE_WORD_DEF = 16;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // address bits for a store of the given depth, at least one
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ rtl/i8mm_req_if.sv @@
`timescale 1ns / 1ps

interface i8mm_req_if;
    import i8mm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [DATA_W-1:0]       write_data;

    modport source (output valid, output cmd, output word_index, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input word_index, input write_data,
                    output ready);
endinterface

@@ rtl/i8mm_rsp_if.sv @@
`timescale 1ns / 1ps

interface i8mm_rsp_if;
    import i8mm_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_level;

    modport source (output valid, output read_data, output irq_level, input ready);
    modport sink   (input valid, input read_data, input irq_level, output ready);
endinterface

@@ rtl/i8mm_ram.sv @@
`timescale 1ns / 1ps

module i8mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = i8mm_pkg::addr_w(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/int8_matmul_register_device_top.sv @@
`timescale 1ns / 1ps

// Bus slave for a MATRIX_DIM x MATRIX_DIM signed 8-bit matrix multiply. Each request word is
// one 32-bit read or write at a word index and gets exactly one response word; irq_level in
// the response is the done flag after that access. A, B and C sit in RAMs with separate write
// and read ports, so ordinary reads and writes complete at one word per cycle while responses
// are accepted, the response registered in the cycle after the request is taken. A control
// write with bit 0 set runs the product on one shared 8x8 multiplier and accumulator, one
// multiply-add per cycle over the r, c, k loop; its response arrives once the last C word is
// written, and no request is taken meanwhile. A status read returns done in bit 0 and clears
// done and the interrupt. Stores read as zero until written, no clearing pass after reset.
module int8_matmul_register_device_top #(
    parameter int MATRIX_DIM  = i8mm_pkg::MATRIX_DIM_DEF,
    parameter int A_BASE_WORD = i8mm_pkg::A_BASE_WORD_DEF,
    parameter int B_BASE_WORD = i8mm_pkg::B_BASE_WORD_DEF,
    parameter int CTRL_WORD   = i8mm_pkg::CTRL_WORD_DEF,
    parameter int STATUS_WORD = i8mm_pkg::STATUS_WORD_DEF,
    parameter int C_BASE_WORD = i8mm_pkg::C_BASE_WORD_DEF
) (
    input logic         clk,
    input logic         rst_n,
    i8mm_req_if.sink    req,
    i8mm_rsp_if.source  rsp
);
    import i8mm_pkg::*;

    localparam int ELEMS        = MATRIX_DIM * MATRIX_DIM;
    localparam int PACKED_WORDS = (ELEMS + LANES - 1) / LANES;
    localparam int IDX_W        = addr_w(ELEMS);
    localparam int PW_W         = addr_w(PACKED_WORDS);
    localparam int DIM_W        = $clog2(MATRIX_DIM);
    localparam int ACC_W        = 2 * BYTE_W + 1 + $clog2(MATRIX_DIM);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;
    typedef enum logic [2:0] {SEL_ZERO, SEL_A, SEL_B, SEL_C, SEL_STATUS} sel_t;

    // control state
    state_t                  state_reg, state_next;
    logic                    done_reg, done_next;
    logic                    c_filled_reg, c_filled_next;
    logic [PACKED_WORDS-1:0] a_row_ok_reg, a_row_ok_next;
    logic [PACKED_WORDS-1:0] b_row_ok_reg, b_row_ok_next;
    logic                    out_valid_reg, out_valid_next;
    sel_t                    out_sel_reg, out_sel_next;
    logic [LANES-1:0]        out_mask_reg, out_mask_next;
    logic                    out_stat_reg, out_stat_next;
    logic [DIM_W-1:0]        r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s2_valid_reg, s2_valid_next;

    // multiply pipeline payload
    logic [1:0]               s1_a_lane_reg, s1_b_lane_reg;
    logic                     s1_a_ok_reg, s1_b_ok_reg;
    logic                     s1_first_reg, s1_last_reg;
    logic [IDX_W-1:0]         s1_cidx_reg;
    logic signed [2*BYTE_W-1:0] prod_reg;
    logic                     s2_first_reg, s2_last_reg;
    logic [IDX_W-1:0]         s2_cidx_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    // decode
    logic             accept, is_write;
    logic             hit_a, hit_b, hit_ctrl, hit_stat, hit_c;
    int               addr_i, a_off, b_off, c_off, win_off;
    logic [LANES-1:0] lane_ok;
    logic [PW_W-1:0]  win_word;
    logic             is_start;

    // sequencer addressing
    logic [IDX_W-1:0] a_idx, b_idx, cmp_cidx;
    logic             k_last, c_last, r_last;

    // RAM ports
    logic              a_we, b_we, a_re, b_re, c_we, c_re;
    logic [PW_W-1:0]   a_raddr, b_raddr;
    logic [IDX_W-1:0]  c_raddr;
    logic [DATA_W-1:0] a_rdata, b_rdata, c_rdata, c_wdata;

    logic signed [BYTE_W-1:0] a_byte, b_byte;
    logic signed [ACC_W-1:0]  sum;
    logic [DATA_W-1:0]        lane_mask32;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;
    assign is_write  = (req.cmd == CMD_WRITE);

    always_comb
    begin
        addr_i   = int'(req.word_index);
        a_off    = addr_i - A_BASE_WORD;
        b_off    = addr_i - B_BASE_WORD;
        c_off    = addr_i - C_BASE_WORD;
        hit_a    = (addr_i >= A_BASE_WORD) && (a_off < PACKED_WORDS);
        hit_b    = !hit_a && (addr_i >= B_BASE_WORD) && (b_off < PACKED_WORDS);
        hit_ctrl = !hit_a && !hit_b && (addr_i == CTRL_WORD);
        hit_stat = !hit_a && !hit_b && (addr_i == STATUS_WORD);
        hit_c    = !hit_a && !hit_b && !hit_stat && (addr_i >= C_BASE_WORD)
                   && (c_off < ELEMS);
        win_off  = hit_a ? a_off : b_off;
        win_word = PW_W'(win_off);
        for (int j = 0; j < LANES; j++)
        begin
            // bytes past the end of the store are dropped
            lane_ok[j] = (win_off * LANES + j) < ELEMS;
        end
    end

    assign is_start = accept && is_write && hit_ctrl && req.write_data[0];

    assign a_idx    = IDX_W'(r_reg) * IDX_W'(MATRIX_DIM) + IDX_W'(k_reg);
    assign b_idx    = IDX_W'(k_reg) * IDX_W'(MATRIX_DIM) + IDX_W'(c_reg);
    assign cmp_cidx = IDX_W'(r_reg) * IDX_W'(MATRIX_DIM) + IDX_W'(c_reg);
    assign k_last   = (k_reg == DIM_W'(MATRIX_DIM - 1));
    assign c_last   = (c_reg == DIM_W'(MATRIX_DIM - 1));
    assign r_last   = (r_reg == DIM_W'(MATRIX_DIM - 1));

    // RAM port muxing: bus side when idle, sequencer while running
    assign a_we    = accept && is_write && hit_a;
    assign b_we    = accept && is_write && hit_b;
    assign a_re    = (accept && !is_write && hit_a) || (state_reg == ST_RUN);
    assign b_re    = (accept && !is_write && hit_b) || (state_reg == ST_RUN);
    assign a_raddr = (state_reg == ST_RUN) ? PW_W'(a_idx >> 2) : win_word;
    assign b_raddr = (state_reg == ST_RUN) ? PW_W'(b_idx >> 2) : win_word;
    assign c_re    = accept && !is_write && hit_c;
    assign c_raddr = IDX_W'(c_off);

    assign a_byte = s1_a_ok_reg ? signed'(a_rdata[{s1_a_lane_reg, 3'b000} +: BYTE_W]) : '0;
    assign b_byte = s1_b_ok_reg ? signed'(b_rdata[{s1_b_lane_reg, 3'b000} +: BYTE_W]) : '0;

    assign sum     = (s2_first_reg ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
    assign c_we    = s2_valid_reg && s2_last_reg;
    assign c_wdata = DATA_W'(sum);

    i8mm_ram #(.WIDTH(DATA_W), .DEPTH(PACKED_WORDS)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (win_word),
        .wdata (req.write_data),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    i8mm_ram #(.WIDTH(DATA_W), .DEPTH(PACKED_WORDS)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (win_word),
        .wdata (req.write_data),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    i8mm_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_c_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (s2_cidx_reg),
        .wdata (c_wdata),
        .re    (c_re),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        c_filled_next  = c_filled_reg;
        a_row_ok_next  = a_row_ok_reg;
        b_row_ok_next  = b_row_ok_reg;
        out_valid_next = out_valid_reg;
        out_sel_next   = out_sel_reg;
        out_mask_next  = out_mask_reg;
        out_stat_next  = out_stat_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        s1_valid_next  = 1'b0;
        s2_valid_next  = s1_valid_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_sel_next   = SEL_ZERO;
                    if (is_write)
                    begin
                        if (hit_a)
                        begin
                            a_row_ok_next[win_word] = 1'b1;
                        end
                        if (hit_b)
                        begin
                            b_row_ok_next[win_word] = 1'b1;
                        end
                        if (is_start)
                        begin
                            done_next      = 1'b0;
                            out_valid_next = 1'b0;
                            r_next         = '0;
                            c_next         = '0;
                            k_next         = '0;
                            state_next     = ST_RUN;
                        end
                    end
                    else if (hit_a)
                    begin
                        out_sel_next  = SEL_A;
                        out_mask_next = lane_ok & {LANES{a_row_ok_reg[win_word]}};
                    end
                    else if (hit_b)
                    begin
                        out_sel_next  = SEL_B;
                        out_mask_next = lane_ok & {LANES{b_row_ok_reg[win_word]}};
                    end
                    else if (hit_stat)
                    begin
                        out_sel_next  = SEL_STATUS;
                        out_stat_next = done_reg;
                        done_next     = 1'b0;
                    end
                    else if (hit_c)
                    begin
                        out_sel_next = SEL_C;
                    end
                end
            end

            ST_RUN:
            begin
                s1_valid_next = 1'b1;
                if (k_last)
                begin
                    k_next = '0;
                    if (c_last)
                    begin
                        c_next = '0;
                        if (r_last)
                        begin
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                // last C write has landed once both stages are empty
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    done_next      = 1'b1;
                    c_filled_next  = 1'b1;
                    out_valid_next = 1'b1;
                    out_sel_next   = SEL_ZERO;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            c_filled_reg  <= 1'b0;
            a_row_ok_reg  <= '0;
            b_row_ok_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_sel_reg   <= SEL_ZERO;
            out_mask_reg  <= '0;
            out_stat_reg  <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            c_filled_reg  <= c_filled_next;
            a_row_ok_reg  <= a_row_ok_next;
            b_row_ok_reg  <= b_row_ok_next;
            out_valid_reg <= out_valid_next;
            out_sel_reg   <= out_sel_next;
            out_mask_reg  <= out_mask_next;
            out_stat_reg  <= out_stat_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
        end
    end

    // multiply-accumulate pipeline: RAM read, byte select and multiply, accumulate
    always_ff @(posedge clk)
    begin
        s1_a_lane_reg <= a_idx[1:0];
        s1_b_lane_reg <= b_idx[1:0];
        s1_a_ok_reg   <= a_row_ok_reg[PW_W'(a_idx >> 2)];
        s1_b_ok_reg   <= b_row_ok_reg[PW_W'(b_idx >> 2)];
        s1_first_reg  <= (k_reg == '0);
        s1_last_reg   <= k_last;
        s1_cidx_reg   <= cmp_cidx;
        prod_reg      <= a_byte * b_byte;
        s2_first_reg  <= s1_first_reg;
        s2_last_reg   <= s1_last_reg;
        s2_cidx_reg   <= s1_cidx_reg;
        if (s2_valid_reg)
        begin
            acc_reg <= sum;
        end
    end

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            lane_mask32[j*BYTE_W +: BYTE_W] = out_mask_reg[j] ? BYTE_MASK : '0;
        end
    end

    always_comb
    begin
        unique case (out_sel_reg)
            SEL_A:      rsp.read_data = a_rdata & lane_mask32;
            SEL_B:      rsp.read_data = b_rdata & lane_mask32;
            SEL_C:      rsp.read_data = c_filled_reg ? c_rdata : '0;
            SEL_STATUS: rsp.read_data = DATA_W'(out_stat_reg);
            default:    rsp.read_data = '0;
        endcase
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.irq_level = done_reg;

    a_no_rsp_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !out_valid_reg)
        else $error("response word pending while multiply runs");

    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        is_start |=> (!done_reg && (state_reg == ST_RUN)))
        else $error("start write did not clear done and launch the sequencer");

    a_pipe_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> (state_reg != ST_IDLE))
        else $error("multiply pipeline active while idle");

    a_done_with_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> (out_valid_reg && c_filled_reg))
        else $error("done raised without the start response word");
endmodule

@@ dv/int8_matmul_register_device_top_test.sv @@
`timescale 1ns / 1ps

module int8_matmul_register_device_top_test;
    import i8mm_pkg::*;

    localparam int DIM      = MATRIX_DIM_DEF;
    localparam int ELEMS    = DIM * DIM;
    localparam int PACKED   = (ELEMS + LANES - 1) / LANES;
    localparam int IDX_W    = addr_w(ELEMS);
    localparam int N_WORDS  = 1 << WORD_INDEX_W;
    localparam int A_BASE   = A_BASE_WORD_DEF;
    localparam int B_BASE   = B_BASE_WORD_DEF;
    localparam int CTRL     = CTRL_WORD_DEF;
    localparam int STATUS   = STATUS_WORD_DEF;
    localparam int C_BASE   = C_BASE_WORD_DEF;
    // the limit covers every word being a start
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 120;
    localparam int N_PRESSURE  = 40;
    localparam int N_RANDOM    = 240;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    int cycle_count;
    int n_sent         = 0;
    int n_rcvd         = 0;
    int n_errors       = 0;
    int hold_req_count = 0;

    rsp_word_t exp_q[$];

    logic [BYTE_W-1:0] model_a [ELEMS];
    logic [BYTE_W-1:0] model_b [ELEMS];
    logic [DATA_W-1:0] model_c [ELEMS];
    logic              model_done;

    i8mm_req_if req ();
    i8mm_rsp_if rsp ();

    int8_matmul_register_device_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ---------------- predictor ----------------

    function automatic void model_reset();
        for (int j = 0; j < ELEMS; j++)
        begin
            model_a[j] = '0;
            model_b[j] = '0;
            model_c[j] = '0;
        end
        model_done = 1'b0;
    endfunction

    function automatic logic in_window(input int addr, input int base, input int len);
        return (addr >= base) && (addr - base < len);
    endfunction

    function automatic logic [DATA_W-1:0] pack_word(input logic is_b, input int word_i);
        logic [DATA_W-1:0] w;
        int                e;
        w = '0;
        for (int j = 0; j < LANES; j++)
        begin
            e = word_i * LANES + j;
            if (e < ELEMS)
            begin
                w[j*BYTE_W +: BYTE_W] = is_b ? model_b[IDX_W'(e)] : model_a[IDX_W'(e)];
            end
        end
        return w;
    endfunction

    function automatic void unpack_word(input logic is_b, input int word_i,
                                        input logic [DATA_W-1:0] val);
        int e;
        for (int j = 0; j < LANES; j++)
        begin
            e = word_i * LANES + j;
            if (e < ELEMS)
            begin
                if (is_b)
                begin
                    model_b[IDX_W'(e)] = val[j*BYTE_W +: BYTE_W];
                end
                else
                begin
                    model_a[IDX_W'(e)] = val[j*BYTE_W +: BYTE_W];
                end
            end
        end
    endfunction

    function automatic void multiply_all();
        int sum;
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                sum = 0;
                for (int k = 0; k < DIM; k++)
                begin
                    sum += int'($signed(model_a[IDX_W'(r * DIM + k)]))
                         * int'($signed(model_b[IDX_W'(k * DIM + c)]));
                end
                model_c[IDX_W'(r * DIM + c)] = DATA_W'(sum);
            end
        end
        model_done = 1'b1;
    endfunction

    function automatic rsp_word_t model_step(input logic cmd_i, input int addr,
                                             input logic [DATA_W-1:0] val);
        rsp_word_t         res;
        logic [DATA_W-1:0] rd;
        rd = '0;
        if (cmd_i == CMD_WRITE)
        begin
            if (in_window(addr, A_BASE, PACKED))
            begin
                unpack_word(1'b0, addr - A_BASE, val);
            end
            else if (in_window(addr, B_BASE, PACKED))
            begin
                unpack_word(1'b1, addr - B_BASE, val);
            end
            else if (addr == CTRL)
            begin
                if (val[0])
                begin
                    model_done = 1'b0;
                    multiply_all();
                end
            end
        end
        else
        begin
            if (in_window(addr, A_BASE, PACKED))
            begin
                rd = pack_word(1'b0, addr - A_BASE);
            end
            else if (in_window(addr, B_BASE, PACKED))
            begin
                rd = pack_word(1'b1, addr - B_BASE);
            end
            else if (addr == STATUS)
            begin
                rd         = DATA_W'(model_done);
                model_done = 1'b0;
            end
            else if (in_window(addr, C_BASE, ELEMS))
            begin
                rd = model_c[IDX_W'(addr - C_BASE)];
            end
        end
        res.read_data = rd;
        res.irq_level = model_done;
        return res;
    endfunction

    // ---------------- driving ----------------

    task automatic send_item(input logic cmd_i, input int addr, input logic [DATA_W-1:0] val);
        int gap;
        gap = int'($urandom_range(0, 7));
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.cmd        <= cmd_i;
        req.word_index <= WORD_INDEX_W'(addr);
        req.write_data <= val;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        exp_q.push_back(model_step(cmd_i, addr, val));
        n_sent++;
    endtask

    task automatic write_word(input int addr, input logic [DATA_W-1:0] val);
        send_item(CMD_WRITE, addr, val);
    endtask

    task automatic read_word(input int addr);
        send_item(CMD_READ, addr, $urandom());
    endtask

    task automatic load_fill(input logic [DATA_W-1:0] a_val, input logic [DATA_W-1:0] b_val);
        for (int w = 0; w < PACKED; w++)
        begin
            write_word(A_BASE + w, a_val);
        end
        for (int w = 0; w < PACKED; w++)
        begin
            write_word(B_BASE + w, b_val);
        end
    endtask

    task automatic load_random();
        for (int w = 0; w < PACKED; w++)
        begin
            write_word(A_BASE + w, $urandom());
        end
        for (int w = 0; w < PACKED; w++)
        begin
            write_word(B_BASE + w, $urandom());
        end
    endtask

    task automatic start_and_collect();
        write_word(CTRL, {31'($urandom()), 1'b1});
        for (int j = 0; j < ELEMS; j++)
        begin
            read_word(C_BASE + j);
        end
        read_word(STATUS);
        read_word(STATUS);
    endtask

    task automatic random_item();
        int sel;
        int w;
        sel = int'($urandom_range(0, 99));
        w   = int'($urandom_range(0, PACKED - 1));
        if (sel < 8)
        begin
            write_word(CTRL, {31'($urandom()), 1'b1});
        end
        else if (sel < 14)
        begin
            read_word(STATUS);
        end
        else if (sel < 34)
        begin
            write_word(((sel & 1) != 0) ? B_BASE + w : A_BASE + w, $urandom());
        end
        else if (sel < 54)
        begin
            read_word(((sel & 1) != 0) ? B_BASE + w : A_BASE + w);
        end
        else if (sel < 70)
        begin
            read_word(C_BASE + int'($urandom_range(0, ELEMS - 1)));
        end
        else if (sel < 85)
        begin
            write_word(int'($urandom_range(0, N_WORDS - 1)), $urandom());
        end
        else
        begin
            read_word(int'($urandom_range(0, N_WORDS - 1)));
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_reads();
        for (int w = 0; w < N_WORDS; w++)
        begin
            read_word(w);
        end
    endtask

    task automatic test_ctrl_and_unmapped();
        int addr;
        write_word(CTRL, 32'hFFFF_FFFE);
        read_word(STATUS);
        read_word(CTRL);
        write_word(STATUS, 32'h0000_0001);
        write_word(C_BASE, 32'hDEAD_BEEF);
        write_word(C_BASE + ELEMS - 1, 32'h1234_5678);
        read_word(C_BASE);
        for (int w = STATUS + 1; w < C_BASE; w++)
        begin
            write_word(w, $urandom());
            read_word(w);
        end
        for (int j = 0; j < 6; j++)
        begin
            addr = C_BASE + ELEMS + int'($urandom_range(0, N_WORDS - 1 - C_BASE - ELEMS));
            write_word(addr, {31'($urandom()), 1'b1});
            read_word(addr);
        end
        // product of stores never written
        write_word(CTRL, 32'h0000_0001);
        read_word(STATUS);
        read_word(STATUS);
        for (int j = 0; j < 4; j++)
        begin
            read_word(C_BASE + j);
        end
        read_word(CTRL);
    endtask

    task automatic test_window_rw();
        for (int round = 0; round < 2; round++)
        begin
            load_random();
            for (int w = 0; w < PACKED; w++)
            begin
                read_word(A_BASE + w);
            end
            for (int w = 0; w < PACKED; w++)
            begin
                read_word(B_BASE + w);
            end
        end
    endtask

    task automatic test_multiply();
        for (int run = 0; run < 3; run++)
        begin
            load_random();
            start_and_collect();
        end
    endtask

    task automatic test_extreme_values();
        load_fill(32'h8080_8080, 32'h8080_8080);
        start_and_collect();
        load_fill(32'h8080_8080, 32'h7F7F_7F7F);
        start_and_collect();
    endtask

    task automatic test_backpressure();
        hold_req_count++;
        repeat (N_PRESSURE) random_item();
    endtask

    task automatic test_random_mix();
        repeat (N_RANDOM) random_item();
    endtask

    // ---------------- response side ----------------

    initial
    begin : rsp_side
        int        gap;
        int        holds_served;
        rsp_word_t got;
        rsp_word_t want;
        holds_served = 0;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = int'($urandom_range(0, 7));
            if (holds_served != hold_req_count)
            begin
                holds_served++;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
            begin
                @(posedge clk);
            end
            got.read_data = rsp.read_data;
            got.irq_level = rsp.irq_level;
            n_rcvd++;
            if (exp_q.size() == 0)
            begin
                $error("unexpected response word: read_data %h", got.read_data);
                n_errors++;
            end
            else
            begin
                want = exp_q.pop_front();
                if (got.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                    n_errors++;
                end
                if (got.irq_level !== want.irq_level)
                begin
                    $error("irq_level: expected %0b, got %0b", want.irq_level, got.irq_level);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $error("cycle limit of %0d reached", CYCLE_LIMIT);
                $display("FAIL int8_matmul_register_device_top");
                $finish;
            end
        end
    end

    initial
    begin
        model_reset();
        req.valid      <= 1'b0;
        req.cmd        <= CMD_READ;
        req.word_index <= '0;
        req.write_data <= '0;
        rst_n          <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_reads();
        test_ctrl_and_unmapped();
        test_window_rw();
        test_multiply();
        test_extreme_values();
        test_backpressure();
        test_random_mix();

        req.valid <= 1'b0;
        while ((n_rcvd != n_sent) || (exp_q.size() != 0))
        begin
            @(posedge clk);
        end
        if (n_errors == 0)
        begin
            $display("PASS int8_matmul_register_device_top");
        end
        else
        begin
            $display("FAIL int8_matmul_register_device_top");
        end
        $finish;
    end

endmodule
